FILE: rtl/lprd_pkg.sv
// Package for the length-prefixed request deframer.
// Holds the item and result types, header positions, result kinds and register map.
// No dependencies.
package lprd_pkg;

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [0:0] IDX_TIMEOUT = 1'd0;
	localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd1000;

	// Input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_DROP    = 2'd2;

	// Header byte positions; HDR_PAYLOAD means the header is complete
	localparam logic [2:0] HDR_SYS     = 3'd0;
	localparam logic [2:0] HDR_CODE    = 3'd1;
	localparam logic [2:0] HDR_LEN_HI  = 3'd2;
	localparam logic [2:0] HDR_LEN_LO  = 3'd3;
	localparam logic [2:0] HDR_PAYLOAD = 3'd4;

	localparam logic [31:0] IDLE_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  system_id;
		logic [7:0]  request_code;
		logic [15:0] payload_length;
		logic [15:0] byte_index;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

endpackage

FILE: rtl/lprd_regs.sv
// Configuration register file of the deframer: APB-style access to timeout_ticks.
// Depends on lprd_pkg.
module lprd_regs import lprd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [DATA_W-1:0] timeout_ticks
);

	logic [DATA_W-1:0] timeout_q;
	logic              sel_timeout;

	assign pready      = 1'b1;
	assign sel_timeout = (paddr[2] == IDX_TIMEOUT);

	// Write timeout on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			timeout_q <= pwdata;
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (sel_timeout) begin
			prdata = timeout_q;
		end
	end

	assign timeout_ticks = timeout_q;

endmodule

FILE: rtl/lprd_core.sv
// Deframer datapath: header and payload counters, idle timer and result register.
// Depends on lprd_pkg.
module lprd_core import lprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] timeout_ticks,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_res
);

	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  sys_q, sys_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pcnt_q, pcnt_d;
	logic [31:0] idle_q, idle_d;
	logic        res_valid_q;
	result_t     res_q, res_d;
	logic        emit;
	logic        accept;
	logic [31:0] idle_inc;
	logic [16:0] pcnt_inc;
	logic [15:0] len_lo;
	logic        pay_last;

	// Accept while the result register is empty or being drained
	assign in_ready = !res_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 32'd1;
	assign pcnt_inc = {1'b0, pcnt_q} + 17'd1;
	assign pay_last = pcnt_inc >= {1'b0, len_q};
	assign len_lo   = {len_q[15:8], in_item.data_byte};

	// Next state and result for one word
	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		sys_d     = sys_q;
		code_d    = code_q;
		len_d     = len_q;
		pcnt_d    = pcnt_q;
		idle_d    = idle_q;
		emit      = 1'b0;
		res_d     = '0;
		res_d.system_id      = sys_q;
		res_d.request_code   = code_q;
		res_d.payload_length = len_q;
		if (in_item.command == CMD_TICK) begin
			// Count idle time only while a request is pending
			if (hdr_cnt_q != HDR_SYS) begin
				if (idle_inc >= timeout_ticks) begin
					emit       = 1'b1;
					res_d.kind = KIND_DROP;
					res_d.last = 1'b1;
					hdr_cnt_d  = HDR_SYS;
					sys_d      = '0;
					code_d     = '0;
					len_d      = '0;
					pcnt_d     = '0;
					idle_d     = '0;
				end else begin
					idle_d = idle_inc;
				end
			end
		end else begin
			idle_d = '0;
			case (hdr_cnt_q)
				HDR_SYS: begin
					sys_d     = in_item.data_byte;
					hdr_cnt_d = HDR_CODE;
				end
				HDR_CODE: begin
					code_d    = in_item.data_byte;
					hdr_cnt_d = HDR_LEN_HI;
				end
				HDR_LEN_HI: begin
					len_d     = {in_item.data_byte, 8'h00};
					hdr_cnt_d = HDR_LEN_LO;
				end
				HDR_LEN_LO: begin
					pcnt_d = '0;
					if (len_lo == 16'd0) begin
						// Empty payload: report and start over
						emit                 = 1'b1;
						res_d.kind           = KIND_EMPTY;
						res_d.payload_length = 16'd0;
						res_d.last           = 1'b1;
						hdr_cnt_d            = HDR_SYS;
						sys_d                = '0;
						code_d               = '0;
						len_d                = '0;
					end else begin
						len_d     = len_lo;
						hdr_cnt_d = HDR_PAYLOAD;
					end
				end
				default: begin
					// Payload word
					emit               = 1'b1;
					res_d.kind         = KIND_PAYLOAD;
					res_d.byte_index   = pcnt_q;
					res_d.payload_byte = in_item.data_byte;
					res_d.last         = pay_last;
					if (pay_last) begin
						hdr_cnt_d = HDR_SYS;
						sys_d     = '0;
						code_d    = '0;
						len_d     = '0;
						pcnt_d    = '0;
					end else begin
						pcnt_d = pcnt_inc[15:0];
					end
				end
			endcase
		end
	end

	// Hold request state; advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= HDR_SYS;
			sys_q       <= '0;
			code_q      <= '0;
			len_q       <= '0;
			pcnt_q      <= '0;
			idle_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				hdr_cnt_q   <= hdr_cnt_d;
				sys_q       <= sys_d;
				code_q      <= code_d;
				len_q       <= len_d;
				pcnt_q      <= pcnt_d;
				idle_q      <= idle_d;
				res_valid_q <= emit;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (accept && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = res_valid_q;
	assign out_res   = res_q;

endmodule

FILE: rtl/length_prefixed_request_deframer.sv
// Length-prefixed request deframer, top level.
// Input stream s_*: one word per received byte (s_tuser = 0) or per time tick
// (s_tuser = 1). Each request is a four-byte header (system id, request code,
// 16-bit payload length high byte first) followed by the payload bytes.
// Output stream m_*: one word per payload byte, one word for a request with
// an empty payload, and one drop word when a pending request stays idle for
// timeout_ticks ticks; m_tlast marks the final word of a request or a drop.
// Results are registered: a result appears on m_* in the cycle after the word that causes it.
// Throughput: one input word per cycle unless stalled, set by the single result register
// that follows the header/payload counters and the 32-bit idle compare.
// Stall: s_tready drops only while the result register is full and m_tready
// is low; the pending result holds until taken.
// Reset: timeout_ticks returns to 1000, all request state and the result
// register clear.
// Configuration: timeout_ticks at byte address 0 of the APB-style port.
// Depends on lprd_pkg, lprd_regs and lprd_core.
module length_prefixed_request_deframer import lprd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] data_byte
	input  logic              s_tuser,  // [0] command
	// Output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// [7:0] system_id, [15:8] request_code, [31:16] payload_length,
	// [47:32] byte_index, [55:48] payload_byte
	output logic [55:0]       m_tdata,
	output logic [1:0]        m_tuser,  // [1:0] kind
	output logic              m_tlast
);

	logic [DATA_W-1:0] timeout_ticks;
	item_t             in_item;
	result_t           res;

	lprd_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	assign in_item.command   = s_tuser;
	assign in_item.data_byte = s_tdata;

	lprd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_ticks),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_res       (res)
	);

	// Pack the result word
	assign m_tdata = {res.payload_byte, res.byte_index, res.payload_length,
		res.request_code, res.system_id};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

FILE: rtl/lprd_checker.sv
// Port-level checker for the deframer output stream, bound to the top level.
// Depends on lprd_pkg and length_prefixed_request_deframer.
module lprd_checker import lprd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Payload index stays inside the payload, last only on the final byte
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |->
			m_tdata[47:32] < m_tdata[31:16]
			&& (m_tlast == ({1'b0, m_tdata[47:32]} + 17'd1 == {1'b0, m_tdata[31:16]})))
		else $error("payload index or last flag wrong");

	// Empty request carries zero length, index and byte
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_EMPTY |->
			m_tlast && m_tdata[55:16] == 40'd0)
		else $error("empty request result malformed");

	// Drop ends the request with zero index and byte
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DROP |-> m_tlast && m_tdata[55:32] == 24'd0)
		else $error("drop result malformed");

endmodule

bind length_prefixed_request_deframer lprd_checker u_lprd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: sim/length_prefixed_request_deframer_tb.sv
// Self-checking testbench for the length-prefixed request deframer.
// Drives byte and tick words, predicts every result word in a local model of the
// deframer and checks each output word field by field. Depends on lprd_pkg and the RTL.
module length_prefixed_request_deframer_tb;
	import lprd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned MAX_PRINTED = 40;
	localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = ADDR_W'(4 * int'(IDX_TIMEOUT));

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [7:0] data_byte
	logic              s_tuser = 1'b0; // [0] command
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// [7:0] system_id, [15:8] request_code, [31:16] payload_length,
	// [47:32] byte_index, [55:48] payload_byte
	logic [55:0]       m_tdata;
	logic [1:0]        m_tuser;        // [1:0] kind
	logic              m_tlast;

	// Local model of the deframer
	logic [2:0]  hdr_count = HDR_SYS;
	logic [7:0]  held_sys = '0;
	logic [7:0]  held_code = '0;
	logic [15:0] held_len = '0;
	logic [15:0] pay_count = '0;
	logic [31:0] idle_cnt = '0;
	logic [31:0] timeout_cfg = TIMEOUT_RESET;

	item_t       pending_words [$];
	result_t     expected_words [$];
	item_t       next_word;
	result_t     got_word;
	result_t     want_word;
	idle_mode_t  idle_mode = IDLE_NONE;
	logic        long_hold_go = 1'b0;
	logic        hold_go_q = 1'b0;
	int unsigned hold_left = 0;
	int unsigned queued_total = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	logic        sender_gap;

	length_prefixed_request_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
				what, got, want, cycle_count);
	endtask

	// Build a result word from the header fields held so far
	function automatic result_t make_word(input logic [1:0] kind, input logic [15:0] idx,
			input logic [7:0] value, input logic fin);
		result_t w;
		w.kind = kind;
		w.system_id = held_sys;
		w.request_code = held_code;
		w.payload_length = held_len;
		w.byte_index = idx;
		w.payload_byte = value;
		w.last = fin;
		return w;
	endfunction

	task automatic clear_request();
		hdr_count = HDR_SYS;
		held_sys = '0;
		held_code = '0;
		held_len = '0;
		pay_count = '0;
		idle_cnt = '0;
	endtask

	// Advance the local model by one accepted word and queue any result it causes
	task automatic advance_deframer(input logic cmd, input logic [7:0] b);
		logic fin;
		if (cmd == CMD_TICK) begin
			if (hdr_count != HDR_SYS) begin
				if (idle_cnt != IDLE_MAX)
					idle_cnt = idle_cnt + 32'd1;
				if (idle_cnt >= timeout_cfg) begin
					expected_words.push_back(make_word(KIND_DROP, 16'd0, 8'd0, 1'b1));
					clear_request();
				end
			end
		end else begin
			idle_cnt = '0;
			if (hdr_count != HDR_PAYLOAD) begin
				case (hdr_count)
					HDR_SYS: held_sys = b;
					HDR_CODE: held_code = b;
					HDR_LEN_HI: held_len = {b, 8'h00};
					default: held_len[7:0] = b;
				endcase
				hdr_count = hdr_count + 3'd1;
				if (hdr_count == HDR_PAYLOAD) begin
					pay_count = '0;
					if (held_len == 16'd0) begin
						expected_words.push_back(make_word(KIND_EMPTY, 16'd0, 8'd0, 1'b1));
						clear_request();
					end
				end
			end else begin
				fin = ({1'b0, pay_count} + 17'd1) >= {1'b0, held_len};
				expected_words.push_back(make_word(KIND_PAYLOAD, pay_count, b, fin));
				if (fin)
					clear_request();
				else
					pay_count = pay_count + 16'd1;
			end
		end
	endtask

	// Input driver: offer the next pending word, hold it until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				advance_deframer(s_tuser, s_tdata);
			sender_gap = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 76) ||
				(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 36);
			if (pending_words.size() != 0 && !sender_gap) begin
				next_word = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_word.command;
				s_tdata <= next_word.data_byte;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output monitor: check each taken word, then pick the next ready level
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_go_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_word.kind = m_tuser;
				got_word.system_id = m_tdata[7:0];
				got_word.request_code = m_tdata[15:8];
				got_word.payload_length = m_tdata[31:16];
				got_word.byte_index = m_tdata[47:32];
				got_word.payload_byte = m_tdata[55:48];
				got_word.last = m_tlast;
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", {8'd0, m_tdata[55:32]}, 32'd0);
				end else begin
					want_word = expected_words.pop_front();
					if (got_word.kind !== want_word.kind)
						report_mismatch("kind", 32'(got_word.kind), 32'(want_word.kind));
					if (got_word.system_id !== want_word.system_id)
						report_mismatch("system_id", 32'(got_word.system_id),
							32'(want_word.system_id));
					if (got_word.request_code !== want_word.request_code)
						report_mismatch("request_code", 32'(got_word.request_code),
							32'(want_word.request_code));
					if (got_word.payload_length !== want_word.payload_length)
						report_mismatch("payload_length", 32'(got_word.payload_length),
							32'(want_word.payload_length));
					if (got_word.byte_index !== want_word.byte_index)
						report_mismatch("byte_index", 32'(got_word.byte_index),
							32'(want_word.byte_index));
					if (got_word.payload_byte !== want_word.payload_byte)
						report_mismatch("payload_byte", 32'(got_word.payload_byte),
							32'(want_word.payload_byte));
					if (got_word.last !== want_word.last)
						report_mismatch("last", 32'(got_word.last), 32'(want_word.last));
				end
			end
			hold_go_q <= long_hold_go;
			if (long_hold_go && !hold_go_q) begin
				hold_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				case (idle_mode)
					IDLE_RECEIVER: m_tready <= $urandom_range(0, 99) >= 76;
					IDLE_BOTH: m_tready <= $urandom_range(0, 99) >= 36;
					default: m_tready <= 1'b1;
				endcase
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_item(input logic cmd, input logic [7:0] b);
		item_t w;
		w.command = cmd;
		w.data_byte = b;
		pending_words.push_back(w);
		queued_total++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(CMD_BYTE, b);
	endtask

	// Tick words carry random data so the ignored byte toggles too
	task automatic push_ticks(input int unsigned n);
		repeat (n) push_item(CMD_TICK, 8'($urandom));
	endtask

	task automatic push_header(input logic [7:0] sys, input logic [7:0] code,
			input logic [15:0] len);
		push_byte(sys);
		push_byte(code);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
	endtask

	// Ticks that are enough to drop a pending request at small timeouts
	function automatic int unsigned drop_ticks();
		if (timeout_cfg == 0)
			return 1;
		return (timeout_cfg > 30) ? 30 : timeout_cfg;
	endfunction

	// Mostly well-formed requests with random content, some cut short, ticks and noise
	task automatic gen_traffic(input int unsigned n_items);
		int unsigned start_total;
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		int unsigned k;
		int unsigned gap_at;
		logic [7:0] frame [$];
		start_total = queued_total;
		while (queued_total - start_total < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				k = $urandom_range(0, 99);
				if (pick >= 70)
					len = $urandom_range(1, 10);
				else if (k < 60)
					len = $urandom_range(0, 6);
				else if (k < 97)
					len = $urandom_range(7, 40);
				else
					len = $urandom_range(256, 290);
				frame.delete();
				frame.push_back(8'($urandom));
				frame.push_back(8'($urandom));
				frame.push_back(len[15:8]);
				frame.push_back(len[7:0]);
				for (k = 0; k < len; k++)
					frame.push_back(8'($urandom));
				// cut the request short, then send enough ticks to time it out at small timeouts
				if (pick >= 70) begin
					cut = $urandom_range(1, frame.size() - 1);
					while (frame.size() > cut)
						void'(frame.pop_back());
				end
				gap_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame.size() - 1) : 0;
				for (k = 0; k < frame.size(); k++) begin
					if (k == gap_at && k != 0)
						push_ticks($urandom_range(1, drop_ticks()));
					push_byte(frame[k]);
				end
				if (pick >= 70)
					push_ticks(drop_ticks() + $urandom_range(0, 1));
			end else if (pick < 90) begin
				push_ticks($urandom_range(1, 6));
			end else begin
				repeat ($urandom_range(1, 6))
					push_item(1'($urandom_range(0, 1)), 8'($urandom));
			end
		end
	endtask

	// Wait until every word is sent and every result taken, then let the block settle
	task automatic wait_drained();
		while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TIMEOUT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		timeout_cfg = value;
	endtask

	initial begin
		int unsigned settle;
		#1 arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extremes, empty payload, partial drops, idle clear on a byte
		set_timeout(32'd2);
		push_ticks(1);
		push_header(8'hFF, 8'h00, 16'h0000);
		push_header(8'h00, 8'hFF, 16'h0001);
		push_byte(8'hFF);
		push_byte(8'hA5);
		push_byte(8'h5A);
		push_byte(8'h01);
		push_ticks(2);
		push_byte(8'h12);
		push_ticks(1);
		push_byte(8'h34);
		push_ticks(2);
		push_header(8'hFF, 8'hFF, 16'hFFFF);
		push_byte(8'h00);
		push_ticks(2);
		wait_drained();

		// Zero timeout drops on the first tick; long payload; long receiver hold
		set_timeout(32'd0);
		push_byte(8'h33);
		push_ticks(1);
		push_header(8'h81, 8'h7E, 16'd300);
		repeat (300) push_byte(8'($urandom));
		gen_traffic(40);
		@(posedge clk);
		long_hold_go <= 1'b1;
		@(posedge clk);
		long_hold_go <= 1'b0;
		gen_traffic(120);
		wait_drained();

		set_timeout(32'd1);
		idle_mode = IDLE_SENDER;
		gen_traffic(190);
		wait_drained();

		set_timeout(32'hFFFF_FFFF);
		idle_mode = IDLE_RECEIVER;
		gen_traffic(190);
		wait_drained();

		set_timeout(32'd5);
		idle_mode = IDLE_BOTH;
		gen_traffic(190);
		wait_drained();

		// Pause the sender mid-phase until all results are in
		set_timeout(32'($urandom_range(2, 12)));
		idle_mode = IDLE_NONE;
		gen_traffic(100);
		wait_drained();
		gen_traffic(100);
		wait_drained();

		set_timeout(TIMEOUT_RESET);
		idle_mode = IDLE_BOTH;
		gen_traffic(60);

		// Drain, then wait for the remaining results and for any stray output
		while (pending_words.size() != 0 || s_tvalid)
			@(posedge clk);
		for (settle = 0; settle < 2000 && expected_words.size() != 0; settle++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch("words never received", 32'(expected_words.size()), 32'd0);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
